// ===== src/lrupr_pkg.sv =====
// Package for the LRU page replacement unit: sizes, widths and the cell control struct.
// No dependencies. Used by lrupr_cell and lru_page_replacement_unit.
package lrupr_pkg;

  // Frame row size and page field width
  localparam int MAX_FRAMES = 8;
  localparam int PAGE_WIDTH = 16;

  // Resident count must hold 0..MAX_FRAMES
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  // Fixed port widths
  localparam int FRM_W   = 4;
  localparam int OCC_W   = 4;
  localparam int FAULT_W = 32;

  localparam logic [FRM_W-1:0] FRAMES_RST = FRM_W'(4);

  // Control that the top level hands to each cell in a cycle
  typedef struct packed {
    logic step;   // an item is accepted in this cycle
    logic live;   // cell position is below the resident count
    logic load;   // cell takes the referenced page
    logic evict;  // whole row shifts toward the LRU end
  } cell_ctrl_t;

endpackage

// ===== src/lru_page_replacement_unit.sv =====
// LRU page replacement unit, fully associative: top level with the cell row and output register.
// Depends on lrupr_pkg and lrupr_cell.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with page_number_i. An item is taken at a
//   rising edge where in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o / out_stall_i with hit_o, victim_valid_o, victim_page_o,
//   fault_total_o and occupancy_o; one result item for every input item, in order.
//   The result is registered at the edge that takes the item.
//   Throughput is one item per cycle while the receiver does not stall; the row of frame cells
//   compares every resident page in parallel and shifts the recency order in the same cycle.
//   While the receiver stalls, the result holds and in_stall_o is raised, so at most
//   one result waits; a new item is taken in the cycle the waiting result leaves.
//   Reset empties the frame row, clears the fault count and sets the frame count to 4.
//   cfg_we_i/cfg_data_i write the frame count; the write only lands while no page is
//   resident. A frame count of 0 acts as 1, above the row size as the row size.
module lru_page_replacement_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrupr_pkg::FRM_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lrupr_pkg::PAGE_WIDTH-1:0]  page_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic                              victim_valid_o,
  output logic [lrupr_pkg::PAGE_WIDTH-1:0]  victim_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]     fault_total_o,
  output logic [lrupr_pkg::OCC_W-1:0]       occupancy_o
);

  localparam int N = lrupr_pkg::MAX_FRAMES;

  logic [lrupr_pkg::FRM_W-1:0]      frames_q;
  logic [lrupr_pkg::CNT_W-1:0]      count_q, count_d;
  logic [lrupr_pkg::FAULT_W-1:0]    fault_q, fault_d;
  logic [lrupr_pkg::CNT_W-1:0]      eff_frames;
  logic [lrupr_pkg::CNT_W-1:0]      load_pos;
  logic                             accept;
  logic                             hit;
  logic                             evict;

  logic                             out_valid_q;
  logic                             hit_q;
  logic                             victim_valid_q;
  logic [lrupr_pkg::PAGE_WIDTH-1:0] victim_page_q;

  lrupr_pkg::cell_ctrl_t            ctrl [N];
  logic [lrupr_pkg::PAGE_WIDTH-1:0] cell_page [N+1];
  logic                             seen [N+1];

  // Handshake: take an item unless a result is waiting on a stalled receiver
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the configured frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_q == '0) begin
      eff_frames = lrupr_pkg::CNT_W'(1);
    end else if (32'(frames_q) > N) begin
      eff_frames = lrupr_pkg::CNT_W'(N);
    end else begin
      eff_frames = lrupr_pkg::CNT_W'(frames_q);
    end
  end

  // Frame count register: writable only while the row is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::FRAMES_RST;
    end else if (cfg_we_i && (count_q == '0)) begin
      frames_q <= cfg_data_i;
    end
  end

  // Row of frame cells, position 0 is least recently used
  assign seen[0]      = 1'b0;
  assign cell_page[N] = page_number_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign ctrl[i].step  = accept;
    assign ctrl[i].live  = lrupr_pkg::CNT_W'(i) < count_q;
    assign ctrl[i].load  = lrupr_pkg::CNT_W'(i) == load_pos;
    assign ctrl[i].evict = evict;

    lrupr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[i]),
      .page_i     (page_number_i),
      .nbr_page_i (cell_page[i+1]),
      .seen_i     (seen[i]),
      .seen_o     (seen[i+1]),
      .page_o     (cell_page[i])
    );
  end

  // Decide hit, eviction, new MRU position and counters
  assign hit   = seen[N];
  assign evict = !hit && (count_q >= eff_frames);

  always_comb begin
    if (hit || evict) begin
      load_pos = count_q - lrupr_pkg::CNT_W'(1);
      count_d  = count_q;
    end else begin
      load_pos = count_q;
      count_d  = count_q + lrupr_pkg::CNT_W'(1);
    end
    fault_d = fault_q;
    if (!hit && (fault_q != '1)) begin
      fault_d = fault_q + lrupr_pkg::FAULT_W'(1);
    end
  end

  // Advance the state counters on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fault_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
      fault_q <= fault_d;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q          <= hit;
      victim_valid_q <= evict;
      victim_page_q  <= evict ? cell_page[0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign victim_valid_o = victim_valid_q;
  assign victim_page_o  = victim_page_q;
  assign fault_total_o  = fault_q;
  assign occupancy_o    = lrupr_pkg::OCC_W'(count_q);

  // Resident count never exceeds the row
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= N)
    else $error("resident count beyond frame row");

  // A hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !victim_valid_o)
    else $error("eviction reported on a hit");

  // Resident count never drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> count_q >= $past(count_q))
    else $error("resident count decreased");

  // An eviction happens only with the row filled to the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && evict |=> count_q == $past(eff_frames))
    else $error("eviction with free frames");

endmodule

// ===== src/lrupr_cell.sv =====
// One frame cell of the LRU recency row: holds one page, compares it with the reference.
// Depends on lrupr_pkg. Takes its upper neighbor's page when the row shifts.
module lrupr_cell (
  input  logic                             clk_i,
  input  lrupr_pkg::cell_ctrl_t            ctrl_i,
  input  logic [lrupr_pkg::PAGE_WIDTH-1:0] page_i,
  input  logic [lrupr_pkg::PAGE_WIDTH-1:0] nbr_page_i,
  input  logic                             seen_i,
  output logic                             seen_o,
  output logic [lrupr_pkg::PAGE_WIDTH-1:0] page_o
);

  logic [lrupr_pkg::PAGE_WIDTH-1:0] page_q, page_d;
  logic                             match;
  logic                             shift;

  // Compare and extend the hit chain toward the MRU end
  assign match  = ctrl_i.live && (page_q == page_i);
  assign seen_o = seen_i | match;
  // Shift from the hit position upward, or the whole row on an eviction
  assign shift  = ctrl_i.evict | seen_o;

  // Load the new page, shift in from the neighbor, or hold
  always_comb begin
    page_d = page_q;
    if (ctrl_i.step) begin
      if (ctrl_i.load) begin
        page_d = page_i;
      end else if (shift) begin
        page_d = nbr_page_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o = page_q;

endmodule

// ===== tb/tb_lru_page_replacement_unit.sv =====
// Testbench for lru_page_replacement_unit: a local LRU frame row predicts every result item,
// and each output item is checked in order. Depends on lrupr_pkg and the unit's RTL.
module tb_lru_page_replacement_unit;

  localparam int PAGE_MAX       = (1 << lrupr_pkg::PAGE_WIDTH) - 1;
  localparam int IDLE_PCT       = 28;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_SIZE      = 12;

  typedef logic [lrupr_pkg::PAGE_WIDTH-1:0] page_t;

  typedef struct packed {
    logic                          hit;
    logic                          victim_valid;
    page_t                         victim_page;
    logic [lrupr_pkg::FAULT_W-1:0] fault_total;
    logic [lrupr_pkg::OCC_W-1:0]   occupancy;
  } page_result_t;

  // DUT inputs, all known from time zero
  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        cfg_we      = 1'b0;
  logic [lrupr_pkg::FRM_W-1:0] cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  page_t                       page_number = '0;
  logic                        out_stall   = 1'b0;

  // DUT outputs
  logic                          in_stall;
  logic                          out_valid;
  logic                          hit;
  logic                          victim_valid;
  page_t                         victim_page;
  logic [lrupr_pkg::FAULT_W-1:0] fault_total;
  logic [lrupr_pkg::OCC_W-1:0]   occupancy;

  // Predicted LRU state: index 0 is least recently used
  page_t                         frame_row [lrupr_pkg::MAX_FRAMES];
  int unsigned                   resident_cnt = 0;
  logic [lrupr_pkg::FAULT_W-1:0] fault_cnt    = '0;
  logic [lrupr_pkg::FRM_W-1:0]   frames_reg   = lrupr_pkg::FRAMES_RST;

  page_t        pending_pages[$];
  page_result_t expected_results[$];

  int    mismatch_cnt  = 0;
  logic  item_taken    = 1'b0;
  int    tx_idle_pct   = IDLE_PCT;
  int    rx_idle_pct   = IDLE_PCT;
  bit    tx_pause      = 1'b0;
  int    hold_requests = 0;
  int    hold_served   = 0;
  int    rx_hold_left  = 0;
  int    stuck_cycles  = 0;
  page_t page_pool [POOL_SIZE];
  int    pool_span     = 1;

  lru_page_replacement_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .page_number_i  (page_number),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .victim_valid_o (victim_valid),
    .victim_page_o  (victim_page),
    .fault_total_o  (fault_total),
    .occupancy_o    (occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one page reference to the local frame row and return the expected item
  function automatic page_result_t lru_predict(page_t page);
    page_result_t r;
    int unsigned  limit;
    int unsigned  pos;
    bit           found;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    limit = (frames_reg == 0) ? 1 :
            (frames_reg > lrupr_pkg::MAX_FRAMES) ? lrupr_pkg::MAX_FRAMES : frames_reg;
    for (int unsigned i = 0; i < resident_cnt; i++) begin
      if (!found && frame_row[i] == page) begin
        found = 1'b1;
        pos   = i;
      end
    end
    r.hit = found;
    if (!found) begin
      if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
      if (resident_cnt >= limit) begin
        r.victim_valid = 1'b1;
        r.victim_page  = frame_row[0];
      end
    end
    // Drop the hit page or the victim, closing the gap toward the LRU end
    if (found || r.victim_valid) begin
      for (int unsigned i = pos; i + 1 < resident_cnt; i++) frame_row[i] = frame_row[i + 1];
      resident_cnt--;
    end
    frame_row[resident_cnt] = page;
    resident_cnt++;
    r.fault_total = fault_cnt;
    r.occupancy   = lrupr_pkg::OCC_W'(resident_cnt);
    return r;
  endfunction

  // Append one page to the pending queue
  function automatic void add_pending(page_t page);
    pending_pages = {pending_pages, page};
  endfunction

  // Draw a fresh working set; its span decides how often references hit
  function automatic void refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = page_t'($urandom_range(0, PAGE_MAX));
    if ($urandom_range(0, 3) == 0) page_pool[0] = '0;
    if ($urandom_range(0, 3) == 0) page_pool[1] = '1;
    pool_span = $urandom_range(1, POOL_SIZE);
  endfunction

  // Mostly working-set references with random content, the rest cold pages
  function automatic page_t next_page();
    if ($urandom_range(0, 99) < 75) return page_pool[$urandom_range(0, pool_span - 1)];
    return page_t'($urandom_range(0, PAGE_MAX));
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) refresh_pool();
      add_pending(next_page());
    end
  endtask

  // Hold until no item is queued, offered or waiting at the output
  task automatic wait_drained();
    do @(posedge clk);
    while (!(pending_pages.size() == 0 && !in_valid && !out_valid));
  endtask

  // Write the frame count for one cycle, then resume on a rising edge
  task automatic write_frames(logic [lrupr_pkg::FRM_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Sender: offer a new item once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (pending_pages.size() != 0 && !tx_pause && $urandom_range(0, 99) >= tx_idle_pct) begin
        page_number <= pending_pages.pop_front();
        in_valid    <= 1'b1;
      end else begin
        page_number <= page_t'($urandom_range(0, PAGE_MAX));
        in_valid    <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold when one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_stall    <= 1'b1;
      rx_hold_left <= RX_HOLD_CYCLES;
      hold_served  <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Track config writes and accepted items, check each result item
  always @(posedge clk) begin : result_check
    page_result_t exp_r;
    page_result_t got_r;
    page_result_t pred_r;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_valid && !in_stall;
      // Frame count lands only while no page is resident
      if (cfg_we && resident_cnt == 0) frames_reg = cfg_data;
      if (in_valid && !in_stall) begin
        pred_r           = lru_predict(page_number);
        expected_results = {expected_results, pred_r};
      end
      if (out_valid && !out_stall) begin
        got_r = '{hit, victim_valid, victim_page, fault_total, occupancy};
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result item: hit=%0b victim=%0b/%h faults=%0d occ=%0d",
                     got_r.hit, got_r.victim_valid, got_r.victim_page, got_r.fault_total,
                     got_r.occupancy);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.hit !== exp_r.hit || got_r.victim_valid !== exp_r.victim_valid ||
              got_r.victim_page !== exp_r.victim_page ||
              got_r.fault_total !== exp_r.fault_total ||
              got_r.occupancy !== exp_r.occupancy) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("mismatch: exp hit=%0b victim=%0b/%h faults=%0d occ=%0d",
                       exp_r.hit, exp_r.victim_valid, exp_r.victim_page, exp_r.fault_total,
                       exp_r.occupancy);
              $display("          got hit=%0b victim=%0b/%h faults=%0d occ=%0d",
                       got_r.hit, got_r.victim_valid, got_r.victim_page, got_r.fault_total,
                       got_r.occupancy);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_page_replacement_unit test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [lrupr_pkg::FRM_W-1:0] final_frames;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame count before the first reference: zero, all ones, then the one that sticks
    write_frames('0);
    write_frames('1);
    final_frames = lrupr_pkg::FRM_W'($urandom_range(4, 15));
    write_frames(final_frames);

    // Directed: field extremes, hits at both ends and the middle, fill and evict
    add_pending(16'h0000);
    add_pending(16'hFFFF);
    add_pending(16'h0000);
    add_pending(16'hAAAA);
    add_pending(16'h5555);
    add_pending(16'hFFFF);
    add_pending(16'h8000);
    add_pending(16'h0001);
    add_pending(16'h0001);
    for (int i = 1; i <= 9; i++) add_pending(page_t'(i << 8));
    add_pending(16'h0000);
    add_pending(16'h0500);
    add_pending(16'h7FFF);
    add_pending(16'h0900);
    wait_drained();

    // Writes while pages are resident must be ignored
    write_frames('0);

    // No idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(400);
    wait_drained();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    write_frames(lrupr_pkg::FRM_W'(1));

    // Long receiver hold while the sender keeps offering
    hold_requests++;
    queue_random(300);
    wait_drained();
    write_frames('1);

    // Sender pause until every expected item has come
    queue_random(300);
    while (pending_pages.size() > 150) @(posedge clk);
    tx_pause = 1'b1;
    do @(posedge clk);
    while (in_valid || out_valid);
    repeat ($urandom_range(20, 60)) @(posedge clk);
    tx_pause = 1'b0;
    wait_drained();

    queue_random(900);
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("lru_page_replacement_unit test passed");
    end else begin
      $display("lru_page_replacement_unit test failed");
    end
    $finish;
  end

endmodule
